/* hw/rtl/msf_pkg.sv */
// msf_pkg: shared types and constants for the motion sensor fusion block
// used by every module under hw/rtl, no dependencies

package msf_pkg;

   localparam int DATA_W    = 32;
   localparam int MARGIN_W  = 31;
   localparam int WEIGHT_W  = 17;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   // weight of 1.0 in q1.16
   localparam logic [WEIGHT_W-1:0] Q_ONE = 17'h10000;
   localparam logic signed [DATA_W-1:0] I32_MAX = 32'sh7fff_ffff;

   // register indexes, byte address is 4 * index
   localparam logic [1:0] REG_MOTOR_MARGIN = 2'd0;
   localparam logic [1:0] REG_VEL_WEIGHT   = 2'd1;
   localparam logic [1:0] REG_ACCEL_WEIGHT = 2'd2;

   typedef struct packed {
      logic [MARGIN_W-1:0] motor_margin;
      logic [WEIGHT_W-1:0] velocity_weight;
      logic [WEIGHT_W-1:0] accel_weight;
   } cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] tape_dist_a;
      logic signed [DATA_W-1:0] tape_dist_b;
      logic signed [DATA_W-1:0] wheel_dist_a;
      logic signed [DATA_W-1:0] wheel_dist_b;
      logic signed [DATA_W-1:0] drive_dist;
      logic signed [DATA_W-1:0] wheel_vel_a;
      logic signed [DATA_W-1:0] wheel_vel_b;
      logic signed [DATA_W-1:0] accel_a;
      logic signed [DATA_W-1:0] accel_b;
      logic signed [DATA_W-1:0] accel_c;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] position;
      logic signed [DATA_W-1:0] vel_sample;
      logic signed [DATA_W-1:0] accel_sample;
   } prep_type;

endpackage

/* hw/rtl/msf_csr.sv */
// msf_csr: apb-style register file holding margin and filter weights
// depends on msf_pkg

module msf_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [msf_pkg::CSR_AW-1:0]    paddr,
   input  logic [msf_pkg::CSR_DW-1:0]    pwdata,
   output logic [msf_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready,
   output msf_pkg::cfg_type              cfg
);

   msf_pkg::cfg_type cfg_ff;
   msf_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            msf_pkg::REG_MOTOR_MARGIN: begin
               cfg_in.motor_margin = pwdata[msf_pkg::MARGIN_W-1:0];
            end
            msf_pkg::REG_VEL_WEIGHT: begin
               cfg_in.velocity_weight = pwdata[msf_pkg::WEIGHT_W-1:0];
            end
            msf_pkg::REG_ACCEL_WEIGHT: begin
               cfg_in.accel_weight = pwdata[msf_pkg::WEIGHT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         msf_pkg::REG_MOTOR_MARGIN: begin
            prdata = {1'b0, cfg_ff.motor_margin};
         end
         msf_pkg::REG_VEL_WEIGHT: begin
            prdata = {15'd0, cfg_ff.velocity_weight};
         end
         msf_pkg::REG_ACCEL_WEIGHT: begin
            prdata = {15'd0, cfg_ff.accel_weight};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/msf_prep.sv */
// msf_prep: position fusion, wheel velocity mean and accel median
// combinational, depends on msf_pkg

module msf_prep (
   input  msf_pkg::req_type                  req,
   input  logic [msf_pkg::MARGIN_W-1:0]      motor_margin,
   output msf_pkg::prep_type                 prep
);

   logic signed [31:0] max_tape;
   logic signed [31:0] max_wheel;
   logic signed [31:0] base;
   logic signed [32:0] top_wide;
   logic signed [31:0] top;
   logic signed [31:0] raised;
   logic signed [32:0] vel_sum;
   logic signed [32:0] vel_adj;
   logic signed [31:0] lo_ab;
   logic signed [31:0] hi_ab;
   logic signed [31:0] mid_c;

   always_comb begin
      max_tape  = (req.tape_dist_a > req.tape_dist_b) ? req.tape_dist_a : req.tape_dist_b;
      max_wheel = (req.wheel_dist_a > req.wheel_dist_b) ? req.wheel_dist_a : req.wheel_dist_b;
      base      = (max_tape > max_wheel) ? max_tape : max_wheel;

      // margin is non-negative, so only positive overflow can happen
      top_wide = {base[31], base} + $signed({2'b00, motor_margin});
      top      = (top_wide > $signed({1'b0, msf_pkg::I32_MAX})) ? msf_pkg::I32_MAX
                                                               : top_wide[31:0];
      raised   = (req.drive_dist > base) ? req.drive_dist : base;
      prep.position = (raised < top) ? raised : top;

      // mean truncated toward zero
      vel_sum = {req.wheel_vel_a[31], req.wheel_vel_a}
              + {req.wheel_vel_b[31], req.wheel_vel_b};
      vel_adj = vel_sum + {32'd0, vel_sum[32]};
      prep.vel_sample = vel_adj[32:1];

      lo_ab = (req.accel_a < req.accel_b) ? req.accel_a : req.accel_b;
      hi_ab = (req.accel_a > req.accel_b) ? req.accel_a : req.accel_b;
      mid_c = (hi_ab < req.accel_c) ? hi_ab : req.accel_c;
      prep.accel_sample = (lo_ab > mid_c) ? lo_ab : mid_c;
   end

endmodule

/* hw/rtl/msf_lowpass.sv */
// msf_lowpass: one step of the exponential filter, weight in q1.16
// combinational, depends on msf_pkg

module msf_lowpass (
   input  logic signed [msf_pkg::DATA_W-1:0]   old_val,
   input  logic signed [msf_pkg::DATA_W-1:0]   sample,
   input  logic        [msf_pkg::WEIGHT_W-1:0] weight,
   output logic signed [msf_pkg::DATA_W-1:0]   new_val
);

   logic        [16:0] w_sat;
   logic signed [32:0] diff;
   logic signed [50:0] prod;
   logic signed [50:0] acc;
   logic signed [50:0] acc_adj;

   // old*w + s*(1-w) rewritten as s*2^16 + (old-s)*w, one multiplier
   always_comb begin
      w_sat   = (weight > msf_pkg::Q_ONE) ? msf_pkg::Q_ONE : weight;
      diff    = {old_val[31], old_val} - {sample[31], sample};
      prod    = diff * $signed({1'b0, w_sat});
      acc     = {{3{sample[31]}}, sample, 16'd0} + prod;
      // bias negative sums so the shift truncates toward zero
      acc_adj = acc + (acc[50] ? 51'sd65535 : 51'sd0);
      new_val = acc_adj[47:16];
   end

endmodule

/* hw/rtl/motion_sensor_fusion_top.sv */
// motion_sensor_fusion_top: fuses sensor updates into position, velocity, acceleration
// depends on msf_pkg, msf_csr, msf_prep, msf_lowpass
//
// usage
//   req channel: one sensor update per request (tape, wheel, motor distances,
//   wheel velocities, three accel samples), valid/ready handshake.
//   rsp channel: one result per request, in order: position, filtered
//   velocity and filtered acceleration.
//   csr port: apb-style, motor_margin at 0x0, velocity_weight at 0x4,
//   accel_weight at 0x8; pready is always high. write only while idle.
//   pipeline: three register stages (input, fused samples, result), passed in that order.
//   throughput: one request per cycle while rsp_ready is high; each filter step is one
//   33x18 multiply and a 51-bit add between the sample register and the result register.
//   reset: csr registers, filter states and valid flags clear to zero; data registers do not.
//   stall: while rsp_ready is low, stages fill behind the held result; up to
//   two more requests are taken before req_ready drops.

module motion_sensor_fusion_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [31:0]                req_tape_dist_a,
   input  logic signed [31:0]                req_tape_dist_b,
   input  logic signed [31:0]                req_wheel_dist_a,
   input  logic signed [31:0]                req_wheel_dist_b,
   input  logic signed [31:0]                req_drive_dist,
   input  logic signed [31:0]                req_wheel_vel_a,
   input  logic signed [31:0]                req_wheel_vel_b,
   input  logic signed [31:0]                req_accel_a,
   input  logic signed [31:0]                req_accel_b,
   input  logic signed [31:0]                req_accel_c,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_position,
   output logic signed [31:0]                rsp_velocity,
   output logic signed [31:0]                rsp_acceleration,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [msf_pkg::CSR_AW-1:0]        paddr,
   input  logic [msf_pkg::CSR_DW-1:0]        pwdata,
   output logic [msf_pkg::CSR_DW-1:0]        prdata,
   output logic                              pready
);

   msf_pkg::cfg_type  cfg;
   msf_pkg::req_type  req_in;
   msf_pkg::req_type  req_ff;
   msf_pkg::prep_type prep_in;
   msf_pkg::prep_type prep_ff;

   logic               req_v_ff;
   logic               prep_v_ff;
   logic               rsp_v_ff;
   logic               en_req;
   logic               en_prep;
   logic               en_rsp;

   logic signed [31:0] vel_state_ff;
   logic signed [31:0] vel_state_in;
   logic signed [31:0] acc_state_ff;
   logic signed [31:0] acc_state_in;
   logic signed [31:0] pos_ff;

   msf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // each stage moves when the stage after it is empty or moving
   assign en_rsp    = !rsp_v_ff || rsp_ready;
   assign en_prep   = !prep_v_ff || en_rsp;
   assign en_req    = !req_v_ff || en_prep;
   assign req_ready = en_req;

   always_comb begin
      req_in.tape_dist_a  = req_tape_dist_a;
      req_in.tape_dist_b  = req_tape_dist_b;
      req_in.wheel_dist_a = req_wheel_dist_a;
      req_in.wheel_dist_b = req_wheel_dist_b;
      req_in.drive_dist   = req_drive_dist;
      req_in.wheel_vel_a  = req_wheel_vel_a;
      req_in.wheel_vel_b  = req_wheel_vel_b;
      req_in.accel_a      = req_accel_a;
      req_in.accel_b      = req_accel_b;
      req_in.accel_c      = req_accel_c;
   end

   msf_prep u_prep (
      .req          (req_ff),
      .motor_margin (cfg.motor_margin),
      .prep         (prep_in)
   );

   msf_lowpass u_vel_lp (
      .old_val (vel_state_ff),
      .sample  (prep_ff.vel_sample),
      .weight  (cfg.velocity_weight),
      .new_val (vel_state_in)
   );

   msf_lowpass u_acc_lp (
      .old_val (acc_state_ff),
      .sample  (prep_ff.accel_sample),
      .weight  (cfg.accel_weight),
      .new_val (acc_state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_v_ff     <= 1'b0;
         prep_v_ff    <= 1'b0;
         rsp_v_ff     <= 1'b0;
         vel_state_ff <= '0;
         acc_state_ff <= '0;
      end else begin
         if (en_req) begin
            req_v_ff <= req_valid;
         end
         if (en_prep) begin
            prep_v_ff <= req_v_ff;
         end
         if (en_rsp) begin
            rsp_v_ff <= prep_v_ff;
         end
         // filter state advances only when a request reaches the result stage
         if (en_rsp && prep_v_ff) begin
            vel_state_ff <= vel_state_in;
            acc_state_ff <= acc_state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_req && req_valid) begin
         req_ff <= req_in;
      end
      if (en_prep && req_v_ff) begin
         prep_ff <= prep_in;
      end
      if (en_rsp && prep_v_ff) begin
         pos_ff <= prep_ff.position;
      end
   end

   assign rsp_valid        = rsp_v_ff;
   assign rsp_position     = pos_ff;
   assign rsp_velocity     = vel_state_ff;
   assign rsp_acceleration = acc_state_ff;

   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (req_v_ff && prep_v_ff && rsp_v_ff && !rsp_ready))
      else $error("req_ready low with a free stage");

   a_rsp_from_prep: assert property (@(posedge clock) disable iff (reset)
      (en_rsp && prep_v_ff) |=> rsp_v_ff)
      else $error("request lost between sample and result stage");

   a_vel_hold_at_one: assert property (@(posedge clock) disable iff (reset)
      (en_rsp && prep_v_ff && cfg.velocity_weight >= msf_pkg::Q_ONE)
      |=> $stable(vel_state_ff))
      else $error("velocity filter moved with unity weight");

   a_acc_hold_at_one: assert property (@(posedge clock) disable iff (reset)
      (en_rsp && prep_v_ff && cfg.accel_weight >= msf_pkg::Q_ONE)
      |=> $stable(acc_state_ff))
      else $error("accel filter moved with unity weight");

   a_state_idle: assert property (@(posedge clock) disable iff (reset)
      !(en_rsp && prep_v_ff) |=> ($stable(vel_state_ff) && $stable(acc_state_ff)))
      else $error("filter state changed without a request");

endmodule
